@@ hdl/lrb_pkg.sv @@
// Package for the link recovery backoff controller: link state codes, event codes,
// register indexes, reset values and the socket backoff table.
// No dependencies; every other file of the block refers to it by scoped names.
package lrb_pkg;

    localparam int LINK_W    = 3;
    localparam int ACTION_W  = 3;
    localparam int MS_W      = 20;
    localparam int LEVEL_W   = 3;
    localparam int COUNT_W   = 8;
    localparam int LIMIT_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 20;

    localparam int BACKOFF_STEPS_DEF = 5;

    // Encoded link states as they appear on the result channel.
    localparam logic [LINK_W-1:0] CODE_OFFLINE      = 3'd0;
    localparam logic [LINK_W-1:0] CODE_MODULE_READY = 3'd1;
    localparam logic [LINK_W-1:0] CODE_NET_DOWN     = 3'd2;
    localparam logic [LINK_W-1:0] CODE_NET_READY    = 3'd3;
    localparam logic [LINK_W-1:0] CODE_SOCKET_DOWN  = 3'd4;
    localparam logic [LINK_W-1:0] CODE_RUNNING      = 3'd5;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_RETRY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NET_RETRY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_WAIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIM  = 2'd3;

    localparam logic [MS_W-1:0]    PROBE_RETRY_RST  = 20'd5000;
    localparam logic [MS_W-1:0]    NET_RETRY_RST    = 20'd10000;
    localparam logic [MS_W-1:0]    DEFAULT_WAIT_RST = 20'd1000;
    localparam logic [LIMIT_W-1:0] TIMEOUT_LIM_RST  = 8'd3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_RECOVER       = 3'd0,
        ACT_WAIT          = 3'd1,
        ACT_SEND_FAIL     = 3'd2,
        ACT_PROBE_TIMEOUT = 3'd3,
        ACT_PROBE_OK      = 3'd4,
        ACT_FORCE         = 3'd5
    } t_action;

    typedef enum logic [5:0] {
        LINK_OFFLINE      = 6'b000001,
        LINK_MODULE_READY = 6'b000010,
        LINK_NET_DOWN     = 6'b000100,
        LINK_NET_READY    = 6'b001000,
        LINK_SOCKET_DOWN  = 6'b010000,
        LINK_RUNNING      = 6'b100000
    } t_link;

    function automatic logic [LINK_W-1:0] link_encode(input t_link link);
        logic [LINK_W-1:0] code;
        unique case (link)
            LINK_OFFLINE:      code = CODE_OFFLINE;
            LINK_MODULE_READY: code = CODE_MODULE_READY;
            LINK_NET_DOWN:     code = CODE_NET_DOWN;
            LINK_NET_READY:    code = CODE_NET_READY;
            LINK_SOCKET_DOWN:  code = CODE_SOCKET_DOWN;
            LINK_RUNNING:      code = CODE_RUNNING;
            default:           code = CODE_OFFLINE;
        endcase
        return code;
    endfunction

    // Codes above running are filtered out by the caller.
    function automatic t_link link_decode(input logic [LINK_W-1:0] code);
        t_link link;
        unique case (code)
            CODE_OFFLINE:      link = LINK_OFFLINE;
            CODE_MODULE_READY: link = LINK_MODULE_READY;
            CODE_NET_DOWN:     link = LINK_NET_DOWN;
            CODE_NET_READY:    link = LINK_NET_READY;
            CODE_SOCKET_DOWN:  link = LINK_SOCKET_DOWN;
            CODE_RUNNING:      link = LINK_RUNNING;
            default:           link = LINK_OFFLINE;
        endcase
        return link;
    endfunction

    // Socket backoff: 10 s, 30 s, 1 min, 2 min, then 5 min for every later level.
    function automatic logic [MS_W-1:0] backoff_ms(input logic [LEVEL_W-1:0] level);
        logic [MS_W-1:0] ms;
        unique case (level)
            3'd0:    ms = 20'd10000;
            3'd1:    ms = 20'd30000;
            3'd2:    ms = 20'd60000;
            3'd3:    ms = 20'd120000;
            default: ms = 20'd300000;
        endcase
        return ms;
    endfunction

endpackage

@@ hdl/lrb_if.sv @@
// Valid/ready channel interfaces of the link recovery backoff controller:
// one for event requests and one for result items. Widths come from lrb_pkg.
interface lrb_req_if;
    logic                          valid;
    logic                          ready;
    logic [lrb_pkg::ACTION_W-1:0]  action;
    logic                          probe_answered;
    logic                          net_open_ok;
    logic                          sock_open_ok;
    logic                          net_error;
    logic [lrb_pkg::LINK_W-1:0]    forced_state;

    modport source (
        output valid, action, probe_answered, net_open_ok, sock_open_ok, net_error,
               forced_state,
        input  ready
    );
    modport sink (
        input  valid, action, probe_answered, net_open_ok, sock_open_ok, net_error,
               forced_state,
        output ready
    );
endinterface

interface lrb_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [lrb_pkg::LINK_W-1:0]    link_state;
    logic [lrb_pkg::MS_W-1:0]      wait_ms;
    logic [lrb_pkg::LEVEL_W-1:0]   backoff_level;
    logic [lrb_pkg::COUNT_W-1:0]   timeouts_seen;

    modport source (
        output valid, link_state, wait_ms, backoff_level, timeouts_seen,
        input  ready
    );
    modport sink (
        input  valid, link_state, wait_ms, backoff_level, timeouts_seen,
        output ready
    );
endinterface

@@ hdl/link_recovery_backoff_fsm.sv @@
// Top level of the modem link recovery controller with socket backoff.
// Uses lrb_pkg for codes and the backoff table, lrb_if.sv for the channels.
//
//   channel   direction  handshake       content
//   i_req     in         valid/ready     one event request
//   o_rsp     out        valid/ready     link state, wait, level, timeout count
//   i_cfg_*   in         write enable    register index and data, no read-back
//
// Each request passes from acceptance through the input register into the
// result register. One request per cycle is sustained while o_rsp is ready;
// the link state updates when a request moves into the result register.
// A stall on o_rsp holds the result register and then the input register.
// Synchronous active-low reset clears the link state, backoff level, counter
// and valid flags and restores the configuration reset values.
module link_recovery_backoff_fsm #(
    parameter int BACKOFF_STEPS = lrb_pkg::BACKOFF_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lrb_req_if.sink                         i_req,
    lrb_rsp_if.source                       o_rsp,
    input  logic                            i_cfg_we,
    input  logic [lrb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lrb_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam logic [lrb_pkg::LEVEL_W:0]   STEPS_W    = (lrb_pkg::LEVEL_W+1)'(BACKOFF_STEPS);
    localparam logic [lrb_pkg::LEVEL_W-1:0] LAST_LEVEL = lrb_pkg::LEVEL_W'(BACKOFF_STEPS - 1);

    // Configuration registers.
    logic [lrb_pkg::MS_W-1:0]     r_probe_retry;
    logic [lrb_pkg::MS_W-1:0]     r_net_retry;
    logic [lrb_pkg::MS_W-1:0]     r_default_wait;
    logic [lrb_pkg::LIMIT_W-1:0]  r_timeout_lim;

    // Input register.
    logic                         r_in_valid;
    logic [lrb_pkg::ACTION_W-1:0] r_in_action;
    logic                         r_in_probe;
    logic                         r_in_net_ok;
    logic                         r_in_sock_ok;
    logic                         r_in_net_err;
    logic [lrb_pkg::LINK_W-1:0]   r_in_forced;

    // Link state.
    lrb_pkg::t_link               r_link, n_link;
    logic [lrb_pkg::LEVEL_W-1:0]  r_level, n_level;
    logic [lrb_pkg::COUNT_W-1:0]  r_tctr, n_tctr;
    logic [lrb_pkg::MS_W-1:0]     n_wait;

    // Result register.
    logic                         r_out_valid;
    logic [lrb_pkg::LINK_W-1:0]   r_out_link;
    logic [lrb_pkg::MS_W-1:0]     r_out_wait;
    logic [lrb_pkg::LEVEL_W-1:0]  r_out_level;
    logic [lrb_pkg::COUNT_W-1:0]  r_out_tctr;

    logic                         out_free;
    logic                         advance;
    logic                         accept;
    logic [lrb_pkg::COUNT_W:0]    tctr_inc;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign advance     = r_in_valid && out_free;
    assign i_req.ready = !r_in_valid || out_free;
    assign accept      = i_req.valid && i_req.ready;
    assign tctr_inc    = {1'b0, r_tctr} + (lrb_pkg::COUNT_W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_retry  <= lrb_pkg::PROBE_RETRY_RST;
            r_net_retry    <= lrb_pkg::NET_RETRY_RST;
            r_default_wait <= lrb_pkg::DEFAULT_WAIT_RST;
            r_timeout_lim  <= lrb_pkg::TIMEOUT_LIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lrb_pkg::CFG_PROBE_RETRY:  r_probe_retry  <= i_cfg_data;
                lrb_pkg::CFG_NET_RETRY:    r_net_retry    <= i_cfg_data;
                lrb_pkg::CFG_DEFAULT_WAIT: r_default_wait <= i_cfg_data;
                lrb_pkg::CFG_TIMEOUT_LIM:  r_timeout_lim  <= i_cfg_data[lrb_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_link  = r_link;
        n_level = r_level;
        n_tctr  = r_tctr;
        n_wait  = '0;
        unique case (lrb_pkg::t_action'(r_in_action))
            lrb_pkg::ACT_RECOVER: begin
                unique case (r_link)
                    lrb_pkg::LINK_OFFLINE, lrb_pkg::LINK_MODULE_READY: begin
                        // From offline a full setup only follows an answered probe.
                        if (r_link != lrb_pkg::LINK_OFFLINE || r_in_probe) begin
                            if (r_link == lrb_pkg::LINK_OFFLINE) begin
                                n_tctr = '0;
                            end
                            if (!r_in_net_ok) begin
                                n_link = lrb_pkg::LINK_NET_DOWN;
                            end else begin
                                n_link  = r_in_sock_ok ? lrb_pkg::LINK_RUNNING
                                                       : lrb_pkg::LINK_SOCKET_DOWN;
                                n_level = '0;
                            end
                        end
                    end
                    lrb_pkg::LINK_NET_DOWN, lrb_pkg::LINK_NET_READY: begin
                        if (r_link == lrb_pkg::LINK_NET_READY || r_in_net_ok) begin
                            n_link  = r_in_sock_ok ? lrb_pkg::LINK_RUNNING
                                                   : lrb_pkg::LINK_SOCKET_DOWN;
                            n_level = '0;
                        end
                    end
                    lrb_pkg::LINK_SOCKET_DOWN: begin
                        if (r_in_sock_ok) begin
                            n_link  = lrb_pkg::LINK_RUNNING;
                            n_level = '0;
                        end
                    end
                    default: ;
                endcase
            end
            lrb_pkg::ACT_WAIT: begin
                unique case (r_link)
                    lrb_pkg::LINK_OFFLINE:  n_wait = r_probe_retry;
                    lrb_pkg::LINK_NET_DOWN: n_wait = r_net_retry;
                    lrb_pkg::LINK_SOCKET_DOWN: begin
                        // The level saturates at the last table step.
                        if ({1'b0, r_level} < STEPS_W) begin
                            n_wait = lrb_pkg::backoff_ms(r_level);
                            if (r_level < LAST_LEVEL) begin
                                n_level = r_level + lrb_pkg::LEVEL_W'(1);
                            end
                        end else begin
                            n_wait = lrb_pkg::backoff_ms(LAST_LEVEL);
                        end
                    end
                    default: n_wait = r_default_wait;
                endcase
            end
            lrb_pkg::ACT_SEND_FAIL: begin
                if (r_in_net_err) begin
                    n_link = lrb_pkg::LINK_NET_DOWN;
                end else begin
                    n_link  = lrb_pkg::LINK_SOCKET_DOWN;
                    n_level = '0;
                end
            end
            lrb_pkg::ACT_PROBE_TIMEOUT: begin
                if (tctr_inc >= {1'b0, r_timeout_lim}) begin
                    n_link = lrb_pkg::LINK_OFFLINE;
                    n_tctr = '0;
                end else begin
                    n_tctr = tctr_inc[lrb_pkg::COUNT_W-1:0];
                end
            end
            lrb_pkg::ACT_PROBE_OK: n_tctr = '0;
            lrb_pkg::ACT_FORCE: begin
                if (r_in_forced <= lrb_pkg::CODE_RUNNING) begin
                    n_link = lrb_pkg::link_decode(r_in_forced);
                    if (r_in_forced == lrb_pkg::CODE_RUNNING) begin
                        n_level = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_link      <= lrb_pkg::LINK_OFFLINE;
            r_level     <= '0;
            r_tctr      <= '0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_link  <= n_link;
                r_level <= n_level;
                r_tctr  <= n_tctr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_action  <= i_req.action;
            r_in_probe   <= i_req.probe_answered;
            r_in_net_ok  <= i_req.net_open_ok;
            r_in_sock_ok <= i_req.sock_open_ok;
            r_in_net_err <= i_req.net_error;
            r_in_forced  <= i_req.forced_state;
        end
        if (advance) begin
            r_out_link  <= lrb_pkg::link_encode(n_link);
            r_out_wait  <= n_wait;
            r_out_level <= n_level;
            r_out_tctr  <= n_tctr;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.link_state    = r_out_link;
    assign o_rsp.wait_ms       = r_out_wait;
    assign o_rsp.backoff_level = r_out_level;
    assign o_rsp.timeouts_seen = r_out_tctr;

`ifndef SYNTHESIS
    // The backoff level never runs past the last table step.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LAST_LEVEL)
        else $error("backoff level beyond last step");

    // Only a wait request reports a nonzero wait.
    a_wait_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in_action != lrb_pkg::ACT_WAIT) |=> o_rsp.wait_ms == '0)
        else $error("wait reported for a request other than a wait");

    // Forcing the running state clears the backoff level.
    a_force_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in_action == lrb_pkg::ACT_FORCE)
            && (r_in_forced == lrb_pkg::CODE_RUNNING)
        |=> (o_rsp.backoff_level == '0) && (o_rsp.link_state == lrb_pkg::CODE_RUNNING))
        else $error("forced running state without cleared backoff");

    // A result is only loaded when the input register held a request.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without a request");
`endif

endmodule
